// File: sv/trs_pkg.sv
// Package for the tracker row sequencer: word types, operation codes,
// register map and reset constants. No dependencies.
`default_nettype none

package trs_pkg;

    localparam int ROWS_DEFAULT   = 64;
    localparam int ORDERS_DEFAULT = 256;

    // Song length register and APB address width.
    localparam int LEN_W  = 9;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [0:0] REG_SONG_LENGTH = 1'b0;

    localparam logic [LEN_W-1:0] SONG_LENGTH_RESET = 9'd1;
    localparam logic [7:0]       SPEED_RESET       = 8'd6;

    localparam logic [3:0] OP_TICK        = 4'd0;
    localparam logic [3:0] OP_SET_SPEED   = 4'd1;
    localparam logic [3:0] OP_BREAK       = 4'd2;
    localparam logic [3:0] OP_JUMP        = 4'd3;
    localparam logic [3:0] OP_DELAY       = 4'd4;
    localparam logic [3:0] OP_LOOP        = 4'd5;
    localparam logic [3:0] OP_SKIP_ORDER  = 4'd6;
    localparam logic [3:0] OP_SET_PLAYING = 4'd7;
    localparam logic [3:0] OP_TOGGLE      = 4'd8;

    typedef struct packed {
        logic [3:0] operation;
        logic [7:0] value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] order_index;
        logic [5:0] row_index;
        logic [7:0] tick_in_row;
        logic       row_started;
        logic       run_effects;
        logic       position_changed;
        logic       rejected;
    } out_word_t;

endpackage

`default_nettype wire

// File: sv/tracker_row_sequencer_top.sv
// Throughput: one word per cycle while out_stall is low; an input register and a
// result register split the channels, and an accepted word passes through the input
// register and then the result register, all sequencer state updating once per word.
// Reset (rst_n low, asynchronous): stopped, speed 6, order 0, before the
// first row, no pending break, jump, delay or loop; song length 1.
// Depends on trs_pkg.
`default_nettype none

module tracker_row_sequencer_top
    import trs_pkg::*;
#(
    parameter int ROWS   = ROWS_DEFAULT,
    parameter int ORDERS = ORDERS_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire in_word_t          in_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_word_t              out_word,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int RW1   = ROW_W + 1;
    localparam int ORD_W = $clog2(ORDERS);

    // Handshake and staging registers.
    logic      in_vld_reg;
    in_word_t  in_word_reg;
    logic      res_vld_reg;
    out_word_t res_reg;
    logic      advance;

    // Sequencer state.
    logic [LEN_W-1:0] song_length_reg;
    logic             playing_reg,      playing_next;
    logic [7:0]       speed_reg,        speed_next;
    logic [7:0]       tick_count_reg,   tick_count_next;
    logic [ORD_W-1:0] order_reg,        order_next;
    logic             row_v_reg,        row_v_next;
    logic [ROW_W-1:0] row_reg,          row_next;
    logic             jump_v_reg,       jump_v_next;
    logic [ORD_W-1:0] jump_reg,         jump_next;
    logic             break_v_reg,      break_v_next;
    logic [ROW_W-1:0] break_reg,        break_next;
    logic             delay_v_reg,      delay_v_next;
    logic [7:0]       delay_reg,        delay_next;
    logic             start_v_reg,      start_v_next;
    logic [ROW_W-1:0] start_reg,        start_next;
    logic             rem_v_reg,        rem_v_next;
    logic [7:0]       rem_reg,          rem_next;
    logic             loop_pend_reg,    loop_pend_next;
    out_word_t        res_next;

    logic             cfg_write;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] order_inc;
    logic [ORD_W-1:0] order_adv;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_SONG_LENGTH)
        begin
            prdata = DATA_W'(song_length_reg);
        end
    end

    assign advance   = in_vld_reg && (!res_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && res_vld_reg && out_stall;
    assign out_valid = res_vld_reg;
    assign out_word  = res_reg;

    always_comb
    begin
        if (song_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (song_length_reg > LEN_W'(ORDERS))
        begin
            eff_len = LEN_W'(ORDERS);
        end
        else
        begin
            eff_len = song_length_reg;
        end
    end

    // Next order position with wrap at the song length; a position left
    // beyond a shortened song wraps to zero too.
    assign order_inc = LEN_W'(order_reg) + LEN_W'(1);
    assign order_adv = (order_inc >= eff_len) ? '0 : order_inc[ORD_W-1:0];

    always_comb
    begin
        logic [8:0]     tick_inc;
        logic [RW1-1:0] new_row;
        logic [7:0]     val;
        logic           started;
        logic           effects;
        logic           changed;
        logic           rej;

        playing_next    = playing_reg;
        speed_next      = speed_reg;
        tick_count_next = tick_count_reg;
        order_next      = order_reg;
        row_v_next      = row_v_reg;
        row_next        = row_reg;
        jump_v_next     = jump_v_reg;
        jump_next       = jump_reg;
        break_v_next    = break_v_reg;
        break_next      = break_reg;
        delay_v_next    = delay_v_reg;
        delay_next      = delay_reg;
        start_v_next    = start_v_reg;
        start_next      = start_reg;
        rem_v_next      = rem_v_reg;
        rem_next        = rem_reg;
        loop_pend_next  = loop_pend_reg;
        val      = in_word_reg.value;
        tick_inc = 9'(tick_count_reg) + 9'd1;
        new_row  = '0;
        started  = 1'b0;
        effects  = 1'b0;
        changed  = 1'b0;
        rej      = 1'b0;

        case (in_word_reg.operation)
            OP_TICK:
            begin
                if (playing_reg)
                begin
                    if (tick_inc >= 9'(speed_reg))
                    begin
                        tick_count_next = '0;
                        if (delay_v_reg && delay_reg != '0)
                        begin
                            delay_next = delay_reg - 8'd1;
                        end
                        else
                        begin
                            delay_v_next = 1'b0;
                            // new_row holds the row that the tick lands on.
                            if (jump_v_reg)
                            begin
                                order_next = (LEN_W'(jump_reg) < eff_len) ? jump_reg : '0;
                                new_row    = break_v_reg ? RW1'(break_reg) : '0;
                            end
                            else if (break_v_reg)
                            begin
                                order_next = order_adv;
                                new_row    = RW1'(break_reg);
                            end
                            else
                            begin
                                new_row = row_v_reg ? (RW1'(row_reg) + RW1'(1)) : '0;
                            end
                            if (loop_pend_reg)
                            begin
                                loop_pend_next = 1'b0;
                                if (rem_v_reg && rem_reg != '0)
                                begin
                                    new_row      = start_v_reg ? RW1'(start_reg) : '0;
                                    start_v_next = 1'b0;
                                    start_next   = '0;
                                    rem_next     = rem_reg - 8'd1;
                                end
                                else if (rem_v_reg)
                                begin
                                    rem_v_next   = 1'b0;
                                    start_v_next = 1'b0;
                                    start_next   = '0;
                                end
                            end
                            // Only a plain advance can run past the last row.
                            if (new_row >= RW1'(ROWS))
                            begin
                                row_next   = '0;
                                order_next = order_adv;
                            end
                            else
                            begin
                                row_next = new_row[ROW_W-1:0];
                            end
                            row_v_next   = 1'b1;
                            jump_v_next  = 1'b0;
                            break_v_next = 1'b0;
                            started      = 1'b1;
                            changed      = 1'b1;
                            effects      = 1'b1;
                        end
                    end
                    else
                    begin
                        tick_count_next = tick_inc[7:0];
                        effects         = 1'b1;
                    end
                end
            end
            OP_SET_SPEED:
            begin
                speed_next = val;
            end
            OP_BREAK:
            begin
                if (9'(val) >= 9'(ROWS))
                begin
                    rej = 1'b1;
                end
                else
                begin
                    break_v_next = 1'b1;
                    break_next   = val[ROW_W-1:0];
                end
            end
            OP_JUMP:
            begin
                if (LEN_W'(val) >= eff_len)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    jump_v_next  = 1'b1;
                    jump_next    = val[ORD_W-1:0];
                    break_v_next = 1'b0;
                end
            end
            OP_DELAY:
            begin
                if (!delay_v_reg)
                begin
                    delay_v_next = 1'b1;
                    delay_next   = val;
                end
            end
            OP_LOOP:
            begin
                if (val == '0)
                begin
                    start_v_next = row_v_reg;
                    start_next   = row_reg;
                end
                else
                begin
                    if (!rem_v_reg && start_v_reg)
                    begin
                        rem_v_next = 1'b1;
                        rem_next   = val;
                    end
                    loop_pend_next = 1'b1;
                end
            end
            OP_SKIP_ORDER:
            begin
                if (LEN_W'(val) < eff_len)
                begin
                    order_next      = val[ORD_W-1:0];
                    row_v_next      = 1'b0;
                    row_next        = '0;
                    tick_count_next = speed_reg;
                    changed         = 1'b1;
                end
            end
            OP_SET_PLAYING:
            begin
                playing_next = val[0];
            end
            OP_TOGGLE:
            begin
                playing_next = !playing_reg;
            end
            default:
            begin
            end
        endcase

        res_next.order_index      = 8'(order_next);
        res_next.row_index        = 6'(row_next);
        res_next.tick_in_row      = tick_count_next;
        res_next.row_started      = started;
        res_next.run_effects      = effects;
        res_next.position_changed = changed;
        res_next.rejected         = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            res_vld_reg     <= 1'b0;
            song_length_reg <= SONG_LENGTH_RESET;
            playing_reg     <= 1'b0;
            speed_reg       <= SPEED_RESET;
            tick_count_reg  <= SPEED_RESET;
            order_reg       <= '0;
            row_v_reg       <= 1'b0;
            row_reg         <= '0;
            jump_v_reg      <= 1'b0;
            break_v_reg     <= 1'b0;
            delay_v_reg     <= 1'b0;
            start_v_reg     <= 1'b0;
            start_reg       <= '0;
            rem_v_reg       <= 1'b0;
            loop_pend_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= (in_valid && !in_stall) || (in_vld_reg && !advance);
            res_vld_reg <= advance || (res_vld_reg && out_stall);
            if (cfg_write && paddr[ADDR_W-1:2] == REG_SONG_LENGTH)
            begin
                song_length_reg <= pwdata[LEN_W-1:0];
            end
            if (advance)
            begin
                playing_reg    <= playing_next;
                speed_reg      <= speed_next;
                tick_count_reg <= tick_count_next;
                order_reg      <= order_next;
                row_v_reg      <= row_v_next;
                row_reg        <= row_next;
                jump_v_reg     <= jump_v_next;
                break_v_reg    <= break_v_next;
                delay_v_reg    <= delay_v_next;
                start_v_reg    <= start_v_next;
                start_reg      <= start_next;
                rem_v_reg      <= rem_v_next;
                loop_pend_reg  <= loop_pend_next;
            end
        end
    end

    // Payload registers, qualified by their valid bits.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_word_reg <= in_word;
        end
        if (advance)
        begin
            res_reg    <= res_next;
            jump_reg   <= jump_next;
            break_reg  <= break_next;
            delay_reg  <= delay_next;
            rem_reg    <= rem_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/trs_checker.sv
// Port-level checker for the tracker row sequencer and its bind statement.
// Depends on trs_pkg and tracker_row_sequencer_top.
`default_nettype none

module trs_checker
    import trs_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_word
);

    // A stalled result word is held.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // A new row always runs effects, moves the position and restarts the tick.
    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.row_started |->
            out_word.run_effects && out_word.position_changed &&
            out_word.tick_in_row == 8'd0)
        else $error("row start without effects, position change or tick reset");

    // A rejected command moves nothing.
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.rejected |->
            !out_word.row_started && !out_word.run_effects &&
            !out_word.position_changed)
        else $error("rejected command reported activity");

    // A tick inside a row has counted past zero.
    a_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.run_effects && !out_word.row_started |->
            out_word.tick_in_row != 8'd0)
        else $error("effects tick inside a row with tick count zero");

endmodule

bind tracker_row_sequencer_top trs_checker u_trs_checker (.*);

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the tracker row sequencer: directed event words, then random
// event streams under several song lengths, each result checked against a local model or a table entry.
// Depends on trs_pkg and tracker_row_sequencer_top.

module testbench;
    import trs_pkg::*;

    localparam int ROW_COUNT     = ROWS_DEFAULT;
    localparam int ORDER_MAX     = ORDERS_DEFAULT;
    localparam int PHASE_ITEMS   = 240;
    localparam int HOLD_CYCLES   = 90;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 3000;

    typedef struct packed {
        in_word_t  word;
        bit        typed;
        out_word_t want;
    } stim_row_t;

    // Rows with typed set carry a result that follows directly from the reset state.
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{'{OP_TICK, 8'd0}, 1'b1, '{8'd0, 6'd0, 8'd6, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_BREAK, 8'd64}, 1'b1, '{8'd0, 6'd0, 8'd6, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{OP_JUMP, 8'd4}, 1'b1, '{8'd0, 6'd0, 8'd6, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{OP_SKIP_ORDER, 8'd255}, 1'b1, '{8'd0, 6'd0, 8'd6, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_SET_PLAYING, 8'hFF}, 1'b1, '{8'd0, 6'd0, 8'd6, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_TICK, 8'hFF}, 1'b1, '{8'd0, 6'd0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{'{OP_SET_SPEED, 8'd255}, 1'b0, '0},
        '{'{OP_TICK, 8'd0}, 1'b0, '0},
        '{'{OP_SET_SPEED, 8'd0}, 1'b0, '0},
        '{'{OP_TICK, 8'd0}, 1'b0, '0},
        '{'{OP_LOOP, 8'd0}, 1'b0, '0},
        '{'{OP_SET_SPEED, 8'd2}, 1'b0, '0},
        '{'{OP_LOOP, 8'd3}, 1'b0, '0},
        '{'{OP_TICK, 8'd0}, 1'b0, '0},
        '{'{OP_TICK, 8'd0}, 1'b0, '0},
        '{'{OP_DELAY, 8'd1}, 1'b0, '0},
        '{'{OP_DELAY, 8'd255}, 1'b0, '0},
        '{'{OP_BREAK, 8'd63}, 1'b0, '0},
        '{'{OP_JUMP, 8'd3}, 1'b0, '0},
        '{'{OP_BREAK, 8'd0}, 1'b0, '0},
        '{'{OP_TOGGLE, 8'd0}, 1'b0, '0},
        '{'{OP_TICK, 8'd0}, 1'b0, '0},
        '{'{OP_TOGGLE, 8'hA5}, 1'b0, '0},
        '{'{OP_SKIP_ORDER, 8'd3}, 1'b0, '0},
        '{'{4'hF, 8'h5A}, 1'b0, '0}
    };

    localparam int FIXED_LENGTHS [6] = '{256, 2, 0, 511, 1, 300};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    in_word_t          in_word = '0;
    logic              out_stall = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic              in_stall;
    logic              out_valid;
    out_word_t         out_word;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Model of the sequencer state; negative values mean "none" or "before the first row".
    logic [LEN_W-1:0] song_len_reg;
    bit               is_playing;
    int               speed;
    int               tick_cnt;
    int               order_at;
    int               row_at;
    int               jump_to;
    int               break_to;
    int               delay_left;
    int               loop_row;
    int               loop_left;
    bit               loop_armed;

    out_word_t position_q [$];
    bit        hold_off_req = 1'b0;
    int        burst_left = 0;
    int        error_count = 0;
    int        words_sent = 0;
    int        results_seen = 0;
    int        rows_started = 0;
    int        rejects_seen = 0;
    int        skips_seen = 0;
    int        settings_done = 0;
    int        idle_cycles = 0;

    tracker_row_sequencer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int order_count();
        if (song_len_reg == 0)
            return 1;
        if (song_len_reg > ORDER_MAX)
            return ORDER_MAX;
        return int'(song_len_reg);
    endfunction

    function automatic void bump_order();
        order_at++;
        if (order_at >= order_count())
            order_at = 0;
    endfunction

    // Applies one event word to the model and returns the position it reports.
    function automatic out_word_t play_event(input in_word_t w);
        int        v;
        out_word_t r;
        v = int'(w.value);
        r = '0;
        case (w.operation)
            OP_TICK:
                if (is_playing)
                begin
                    if (tick_cnt + 1 >= speed)
                    begin
                        tick_cnt = 0;
                        if (delay_left > 0)
                            delay_left--;
                        else
                        begin
                            delay_left = -1;
                            if (jump_to != -1)
                            begin
                                order_at = (jump_to < order_count()) ? jump_to : 0;
                                row_at = (break_to == -1) ? -1 : break_to - 1;
                            end
                            else if (break_to != -1)
                            begin
                                bump_order();
                                row_at = break_to - 1;
                            end
                            if (loop_armed)
                            begin
                                loop_armed = 1'b0;
                                if (loop_left > 0)
                                begin
                                    row_at = (loop_row >= 0) ? loop_row - 1 : -1;
                                    loop_row = -1;
                                    loop_left--;
                                end
                                else if (loop_left == 0)
                                begin
                                    loop_left = -1;
                                    loop_row = -1;
                                end
                            end
                            row_at++;
                            if (row_at >= ROW_COUNT)
                            begin
                                row_at = 0;
                                bump_order();
                            end
                            jump_to = -1;
                            break_to = -1;
                            r.row_started = 1'b1;
                            r.run_effects = 1'b1;
                            r.position_changed = 1'b1;
                        end
                    end
                    else
                    begin
                        tick_cnt++;
                        r.run_effects = 1'b1;
                    end
                end
            OP_SET_SPEED:
                speed = v;
            OP_BREAK:
                if (v >= ROW_COUNT)
                    r.rejected = 1'b1;
                else
                    break_to = v;
            OP_JUMP:
                if (v >= order_count())
                    r.rejected = 1'b1;
                else
                begin
                    jump_to = v;
                    break_to = -1;
                end
            OP_DELAY:
                if (delay_left == -1)
                    delay_left = v;
            OP_LOOP:
                if (v == 0)
                    loop_row = row_at;
                else
                begin
                    if (loop_left == -1 && loop_row != -1)
                        loop_left = v;
                    loop_armed = 1'b1;
                end
            OP_SKIP_ORDER:
                if (v < order_count())
                begin
                    order_at = v;
                    row_at = -1;
                    tick_cnt = speed;
                    r.position_changed = 1'b1;
                end
            OP_SET_PLAYING:
                is_playing = w.value[0];
            OP_TOGGLE:
                is_playing = !is_playing;
            default:
                ;
        endcase
        r.order_index = order_at[7:0];
        r.row_index = (row_at < 0) ? 6'd0 : row_at[5:0];
        r.tick_in_row = tick_cnt[7:0];
        return r;
    endfunction

    // Random events lean toward short speeds, delays and loops and toward in-range
    // targets, so that rows, loops and order wraps are reached often.
    function automatic in_word_t random_event();
        in_word_t w;
        int       pick;
        int       len;
        len = order_count();
        pick = $urandom_range(0, 99);
        w.value = 8'($urandom_range(0, 255));
        if (pick < 45)
            w.operation = OP_TICK;
        else if (pick < 53)
        begin
            w.operation = OP_SET_SPEED;
            if ($urandom_range(0, 9) < 8)
                w.value = 8'($urandom_range(0, 4));
        end
        else if (pick < 61)
        begin
            w.operation = OP_BREAK;
            if ($urandom_range(0, 99) < 85)
                w.value = 8'($urandom_range(0, ROW_COUNT - 1));
        end
        else if (pick < 67)
        begin
            w.operation = OP_JUMP;
            if ($urandom_range(0, 99) < 85)
                w.value = 8'($urandom_range(0, len - 1));
        end
        else if (pick < 73)
        begin
            w.operation = OP_DELAY;
            if ($urandom_range(0, 99) != 0)
                w.value = 8'($urandom_range(0, 3));
        end
        else if (pick < 81)
        begin
            w.operation = OP_LOOP;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                w.value = 8'd0;
            else if (pick < 9)
                w.value = 8'($urandom_range(1, 3));
        end
        else if (pick < 87)
        begin
            w.operation = OP_SKIP_ORDER;
            if ($urandom_range(0, 99) < 85)
                w.value = 8'($urandom_range(0, len - 1));
        end
        else if (pick < 93)
        begin
            w.operation = OP_SET_PLAYING;
            if ($urandom_range(0, 9) < 8)
                w.value[0] = 1'b1;
        end
        else if (pick < 96)
            w.operation = OP_TOGGLE;
        else
            w.operation = 4'($urandom_range(9, 15));
        return w;
    endfunction

    // The sender works in bursts; valid drops only in the gap before a burst.
    task automatic offer_word(input in_word_t w, input bit typed, input out_word_t want);
        int        gap;
        out_word_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = play_event(w);
        position_q.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        while (position_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_song_length(input int len);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(4 * REG_SONG_LENGTH);
        pwdata <= DATA_W'(len);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        song_len_reg = len[LEN_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        settings_done++;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    initial
    begin : main_sequence
        int len;
        song_len_reg = SONG_LENGTH_RESET;
        is_playing = 1'b0;
        speed = int'(SPEED_RESET);
        tick_cnt = int'(SPEED_RESET);
        order_at = 0;
        row_at = -1;
        jump_to = -1;
        break_to = -1;
        delay_left = -1;
        loop_row = -1;
        loop_left = -1;
        loop_armed = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_song_length(4);
        foreach (DIRECTED_ROWS[i])
            offer_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        drain_results();

        for (int phase = 0; phase < 7; phase++)
        begin
            len = (phase < 6) ? FIXED_LENGTHS[phase] : $urandom_range(3, 255);
            write_song_length(len);
            if (phase == 0)
                hold_off_req = 1'b1;
            repeat (PHASE_ITEMS) offer_word(random_event(), 1'b0, '0);
            // Leave a jump pending and the order at the top, so the next, possibly
            // shorter, song length sees a stale jump target and an order past the end.
            offer_word('{OP_JUMP, 8'(order_count() - 1)}, 1'b0, '0);
            offer_word('{OP_SKIP_ORDER, 8'(order_count() - 1)}, 1'b0, '0);
            drain_results();
        end

        $display("Sent %0d event words over %0d song length settings; %0d results checked.",
                 words_sent, settings_done, results_seen);
        $display("Seen: %0d row starts, %0d rejected commands, %0d order skips.",
                 rows_started, rejects_seen, skips_seen);
        if (error_count == 0)
            $display("[tracker_row_sequencer_top] OK");
        else
            $display("[tracker_row_sequencer_top] ERROR");
        $finish;
    end

    // Receiver: stall patterns of random density, plus one long hold-off on request.
    initial
    begin : result_receiver
        int mode_left;
        int stall_pct;
        int hold_left;
        mode_left = 0;
        stall_pct = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(16, 160);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                mode_left--;
                out_stall <= ($urandom_range(1, 100) <= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (position_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result word %h arrived with no position expected",
                         $time, out_word);
            end
            else
            begin
                want = position_q.pop_front();
                check_field("order_index", want.order_index, out_word.order_index);
                check_field("row_index", 8'(want.row_index), 8'(out_word.row_index));
                check_field("tick_in_row", want.tick_in_row, out_word.tick_in_row);
                check_field("row_started", 8'(want.row_started), 8'(out_word.row_started));
                check_field("run_effects", 8'(want.run_effects), 8'(out_word.run_effects));
                check_field("position_changed", 8'(want.position_changed),
                            8'(out_word.position_changed));
                check_field("rejected", 8'(want.rejected), 8'(out_word.rejected));
            end
            if (out_word.row_started === 1'b1)
                rows_started++;
            if (out_word.rejected === 1'b1)
                rejects_seen++;
            if (out_word.position_changed === 1'b1 && out_word.row_started !== 1'b1)
                skips_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, position_q.size());
                $display("[tracker_row_sequencer_top] ERROR");
                $finish;
            end
        end
    end

endmodule
